@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file akht_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

@@ rtl/akht_pkg.sv @@
// ----------------------------------------------------------------------------
// akht_pkg
// Types and constants for the address keyed hash table core.
// ----------------------------------------------------------------------------
package akht_pkg;

  localparam logic [63:0] FIB_MULT   = 64'd11400714819323198485;
  localparam int          HASH_SHIFT = 40;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key_addr;
    logic [63:0] new_value;
  } cmd_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] found_value;
    logic [1:0]  status;
  } rsp_t;

endpackage

@@ rtl/address_keyed_hash_table_core.sv @@
// ----------------------------------------------------------------------------
// address_keyed_hash_table_core
// Open addressed hash table, linear probing with tombstones, two banks.
// ----------------------------------------------------------------------------
// channel   signals              direction  accepted when
// command   start, busy, cmd     in         start && !busy
// result    done, rsp            out        done (one cycle, no stall)
//
// An accepted item is hashed (S_HMUL forms split 32 bit multiplies, S_HSUM
// sums them), then each probed slot is read (S_RD) and its registered data
// decided on (S_CHK) in the slot memory, which has one read and one write
// port; the result is registered in S_FIN. A zero key or an unused kind skips
// hash and probe and goes straight to S_FIN. An insert that meets the load
// bound first rebuilds: clear of the other bank (CAPACITY slots), then a walk
// of the old bank, each live entry hashed and reprobed into the new one.
// After reset a clearing pass over all 2*CAPACITY slots holds busy high.
// Results cannot be stalled; busy drops in the cycle the result is shown.
module address_keyed_hash_table_core import akht_pkg::*; #(
  parameter int CAPACITY   = 1024,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output rsp_t rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int AW = IW + 1;
  localparam int CW = IW + 2;

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_RD    = 12'b000000000100,
    S_CHK   = 12'b000000001000,
    S_WCLR  = 12'b000000010000,
    S_WRD   = 12'b000000100000,
    S_WCHK  = 12'b000001000000,
    S_RPRB  = 12'b000010000000,
    S_RCHK  = 12'b000100000000,
    S_FIN   = 12'b001000000000,
    S_HMUL  = 12'b010000000000,
    S_HSUM  = 12'b100000000000
  } state_t;

  state_t state;
  state_t hret;

  logic [KEY_BITS-1:0]   key_mem [2*CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [2*CAPACITY];
  logic [1:0]            mark_mem[2*CAPACITY];

  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic [1:0]            rd_mark;

  logic                  we;
  logic [AW-1:0]         wa, ra;
  logic [KEY_BITS-1:0]   wkey;
  logic [VALUE_BITS-1:0] wval;
  logic [1:0]            wmark;
  logic                  wkv;

  always_ff @(posedge clk) begin
    if (we) begin
      mark_mem[wa] <= wmark;
      if (wkv) begin
        key_mem[wa] <= wkey;
        val_mem[wa] <= wval;
      end
    end
    rd_mark <= mark_mem[ra];
    rd_key  <= key_mem[ra];
    rd_val  <= val_mem[ra];
  end

  logic                  bank;
  logic [CW-1:0]         live_cnt, tomb_cnt;
  logic [1:0]            kind;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] val;
  logic [IW-1:0]         idx, tomb_at, walk;
  logic [IW:0]           nprobe;
  logic                  have_tomb;
  logic [AW:0]           clr;
  logic [KEY_BITS-1:0]   mv_key;
  logic [VALUE_BITS-1:0] mv_val;

  // hash: low 64 bits of key * FIB_MULT from three 32 bit partial products
  logic [63:0] hkey;
  logic [63:0] hp_ll;
  logic [31:0] hp_hl, hp_lh;
  logic [63:0] hsum;
  assign hsum = hp_ll + {hp_hl + hp_lh, 32'd0};

  logic [KEY_BITS-1:0] in_key;
  assign in_key = cmd.key_addr[KEY_BITS-1:0];

  logic bound;
  assign bound = (32'(live_cnt) + 32'(tomb_cnt) + 32'd1) * 32'd2 >= 32'(CAPACITY);

  assign busy = (state != S_IDLE);

  always_comb begin
    we = 1'b0; wa = '0; wkey = key; wval = val; wmark = MARK_EMPTY; wkv = 1'b0;
    ra = {bank, idx};
    case (state)
      S_CLEAR: begin we = 1'b1; wa = clr[AW-1:0]; end
      S_WCLR:  begin we = 1'b1; wa = {~bank, clr[IW-1:0]}; end
      S_WRD:   ra = {bank, walk};
      S_RPRB:  ra = {~bank, idx};
      default: ;
    endcase
    if (state == S_RCHK && rd_mark == MARK_EMPTY) begin
      we = 1'b1; wa = {~bank, idx}; wkey = mv_key; wval = mv_val;
      wmark = MARK_LIVE; wkv = 1'b1;
    end
    if (state == S_CHK) begin
      if (kind == KIND_INSERT) begin
        if (rd_mark == MARK_LIVE && rd_key == key) begin
          we = 1'b1; wa = {bank, idx}; wmark = MARK_LIVE; wkv = 1'b1;
          wkey = rd_key;
        end else if ((rd_mark == MARK_EMPTY || nprobe == (IW+1)'(CAPACITY - 1))
                     && (rd_mark == MARK_EMPTY || have_tomb || rd_mark == MARK_TOMB)
                     && !bound) begin
          we = 1'b1; wmark = MARK_LIVE; wkv = 1'b1;
          wa = {bank, (have_tomb ? tomb_at : idx)};
        end
      end else if (kind == KIND_REMOVE && rd_mark == MARK_LIVE && rd_key == key) begin
        we = 1'b1; wa = {bank, idx}; wmark = MARK_TOMB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr <= '0; bank <= 1'b0; live_cnt <= '0; tomb_cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(2*CAPACITY - 1)) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          kind <= cmd.kind; key <= in_key; val <= cmd.new_value[VALUE_BITS-1:0];
          nprobe <= '0; have_tomb <= 1'b0;
          rsp <= '{hit: 1'b0, found_value: 64'd0,
                   status: (cmd.kind != KIND_UNUSED && in_key == '0) ?
                           STATUS_ZERO : STATUS_DONE};
          if (cmd.kind == KIND_UNUSED) state <= S_FIN;
          else if (in_key == '0) state <= S_FIN;
          else if (cmd.kind == KIND_INSERT && bound) begin
            clr <= '0; state <= S_WCLR;
          end else begin
            hkey <= 64'(in_key); hret <= S_RD; state <= S_HMUL;
          end
        end
        S_HMUL: begin
          hp_ll <= 64'(hkey[31:0]) * 64'(FIB_MULT[31:0]);
          hp_hl <= hkey[63:32] * FIB_MULT[31:0];
          hp_lh <= hkey[31:0] * FIB_MULT[63:32];
          state <= S_HSUM;
        end
        S_HSUM: begin
          idx <= hsum[HASH_SHIFT +: IW];
          state <= hret;
        end
        S_WCLR: begin
          clr <= clr + 1'b1;
          if (clr[IW-1:0] == IW'(CAPACITY - 1)) begin walk <= '0; state <= S_WRD; end
        end
        S_WRD: state <= S_WCHK;
        S_WCHK: begin
          if (rd_mark == MARK_LIVE) begin
            mv_key <= rd_key; mv_val <= rd_val;
            hkey <= 64'(rd_key); hret <= S_RPRB; state <= S_HMUL;
          end else if (walk == IW'(CAPACITY - 1)) begin
            bank <= ~bank; tomb_cnt <= '0;
            hkey <= 64'(key); hret <= S_RD; state <= S_HMUL;
          end else begin walk <= walk + 1'b1; state <= S_WRD; end
        end
        S_RPRB: state <= S_RCHK;
        S_RCHK: begin
          if (rd_mark == MARK_EMPTY) begin
            if (walk == IW'(CAPACITY - 1)) begin
              bank <= ~bank; tomb_cnt <= '0;
              hkey <= 64'(key); hret <= S_RD; state <= S_HMUL;
            end else begin walk <= walk + 1'b1; state <= S_WRD; end
          end else begin idx <= idx + 1'b1; state <= S_RPRB; end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (rd_mark == MARK_LIVE && rd_key == key) begin
            rsp.hit <= 1'b1;
            if (kind == KIND_LOOKUP) rsp.found_value <= 64'(rd_val);
            if (kind == KIND_REMOVE) begin
              if (live_cnt != '0) live_cnt <= live_cnt - 1'b1;
              tomb_cnt <= tomb_cnt + 1'b1;
            end
            state <= S_FIN;
          end else if (rd_mark == MARK_EMPTY || nprobe == (IW+1)'(CAPACITY - 1)) begin
            if (kind == KIND_INSERT) begin
              if ((rd_mark == MARK_EMPTY || have_tomb || rd_mark == MARK_TOMB) && !bound)
              begin
                live_cnt <= live_cnt + 1'b1;
                if ((have_tomb || rd_mark == MARK_TOMB) && tomb_cnt != '0)
                  tomb_cnt <= tomb_cnt - 1'b1;
              end else rsp.status <= STATUS_FULL;
            end
            state <= S_FIN;
          end else begin
            if (rd_mark == MARK_TOMB && !have_tomb) begin
              have_tomb <= 1'b1; tomb_at <= idx;
            end
            idx <= idx + 1'b1; nprobe <= nprobe + 1'b1; state <= S_RD;
          end
        end
        S_FIN: begin done <= 1'b1; state <= S_IDLE; end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

@@ rtl/akht_checker.sv @@
// ----------------------------------------------------------------------------
// akht_checker
// Port level checks for the hash table core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module akht_checker import akht_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);
  `CHK_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `CHK_NEXT(a_done_frees, clk, rst, done, !done)
  `CHK_IMPL(a_full_nohit, clk, rst, done && rsp.status == STATUS_FULL, !rsp.hit)
  `CHK_IMPL(a_zero_clean, clk, rst, done && rsp.status == STATUS_ZERO,
    !rsp.hit && rsp.found_value == 64'd0)
endmodule

bind address_keyed_hash_table_core akht_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
